/* rtl/core/lca_pkg.sv */
// Shared types and constants for the lowest common ancestor engine.
// No dependencies; every other file of the block but lca_ram uses it.
package lca_pkg;

  localparam int NODE_W = 12;
  localparam int DEPTH_IN_W = 8;
  localparam int STEP_W = 9;
  localparam logic [STEP_W-1:0] STEP_LIMIT = 9'd510;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                  mode;
    logic [NODE_W-1:0]     node_a;
    logic [NODE_W-1:0]     node_b;
    logic [NODE_W-1:0]     parent_node;
    logic [DEPTH_IN_W-1:0] node_depth;
  } in_beat_t;

  typedef struct packed {
    logic [NODE_W-1:0] ancestor;
    logic              gave_up;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_A,
    ST_LOAD_B,
    ST_STEP,
    ST_FETCH
  } ctrl_state_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_PASS,
    EMIT_MATCH,
    EMIT_GIVEUP
  } emit_t;

  typedef struct packed {
    logic  write;
    logic  load;
    logic  cap_a;
    logic  cap_b;
    logic  step;
    logic  cap_step;
    emit_t emit;
  } dp_cmd_t;

  typedef struct packed {
    logic zero_case;
    logic nodes_equal;
    logic at_limit;
  } dp_status_t;

endpackage

/* rtl/core/lowest_common_ancestor_engine_unit.sv */
// Lowest common ancestor engine, parent-climb walk over a node table.
// Write beat: stored in the accept cycle, no result, busy stays low.
// Query beat: done strobes after LOAD_A if a node is 0, else after k parent steps
// (k <= 510); each step is one table read (STEP) plus capture (FETCH).
// A new beat may be taken in the cycle the result strobes. Reset clears the
// sequencer, step counter and strobe only; table contents are undefined until written.
module lowest_common_ancestor_engine_unit #(
  parameter int NODE_COUNT = 4096,
  parameter int DEPTH_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  lca_pkg::in_beat_t  item,
  output logic               done,
  output lca_pkg::out_beat_t result
);

  lca_pkg::dp_cmd_t    cmd;
  lca_pkg::dp_status_t status;

  // Sequencer: walks IDLE -> LOAD_A -> LOAD_B -> (STEP <-> FETCH) -> IDLE, or LOAD_A -> IDLE on a zero node.
  lca_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (item.mode),
    .status(status),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Datapath: both walkers cache their node's depth and parent, so a step
  // needs only one table read, at the new node.
  lca_datapath #(
    .NODE_COUNT(NODE_COUNT),
    .DEPTH_BITS(DEPTH_BITS)
  ) u_dp (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .cmd   (cmd),
    .status(status),
    .done  (done),
    .result(result)
  );

  // a result is only produced by a query that kept the block busy
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a running query");

  a_giveup_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.gave_up) |-> (result.ancestor == '0))
    else $error("gave_up with nonzero ancestor");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (item.mode == lca_pkg::MODE_QUERY)) |=> busy)
    else $error("query beat did not start a walk");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (item.mode == lca_pkg::MODE_WRITE)) |=> (!busy && !done))
    else $error("write beat disturbed the sequencer");

endmodule

/* rtl/core/lca_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lca_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/core/lca_ctrl.sv */
// Sequencer for table writes and the parent climb of a query.
// Depends on lca_pkg; drives lca_datapath through dp_cmd_t.
module lca_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                mode,
  input  lca_pkg::dp_status_t status,
  output logic                busy,
  output lca_pkg::dp_cmd_t    cmd
);

  lca_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lca_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.emit = lca_pkg::EMIT_NONE;
    busy = 1'b1;
    unique case (state)
      lca_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (mode == lca_pkg::MODE_WRITE) begin
            cmd.write = 1'b1;
          end else begin
            cmd.load = 1'b1;
            state_next = lca_pkg::ST_LOAD_A;
          end
        end
      end
      lca_pkg::ST_LOAD_A: begin
        cmd.cap_a = 1'b1;
        if (status.zero_case) begin
          cmd.emit = lca_pkg::EMIT_PASS;
          state_next = lca_pkg::ST_IDLE;
        end else begin
          state_next = lca_pkg::ST_LOAD_B;
        end
      end
      lca_pkg::ST_LOAD_B: begin
        cmd.cap_b = 1'b1;
        state_next = lca_pkg::ST_STEP;
      end
      lca_pkg::ST_STEP: begin
        if (status.nodes_equal) begin
          cmd.emit = lca_pkg::EMIT_MATCH;
          state_next = lca_pkg::ST_IDLE;
        end else if (status.at_limit) begin
          cmd.emit = lca_pkg::EMIT_GIVEUP;
          state_next = lca_pkg::ST_IDLE;
        end else begin
          cmd.step = 1'b1;
          state_next = lca_pkg::ST_FETCH;
        end
      end
      lca_pkg::ST_FETCH: begin
        cmd.cap_step = 1'b1;
        state_next = lca_pkg::ST_STEP;
      end
      default: begin
        state_next = lca_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/lca_datapath.sv */
// Node registers, cached depth/parent of both walkers, step counter,
// node table RAM and result register. Depends on lca_pkg and lca_ram.
module lca_datapath #(
  parameter int NODE_COUNT = 4096,
  parameter int DEPTH_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  lca_pkg::in_beat_t   item,
  input  lca_pkg::dp_cmd_t    cmd,
  output lca_pkg::dp_status_t status,
  output logic                done,
  output lca_pkg::out_beat_t  result
);

  localparam int AW = $clog2(NODE_COUNT);
  localparam int NW = lca_pkg::NODE_W;
  localparam int EW = NW + DEPTH_BITS;

  logic [NW-1:0]             na, nb, pa, pb;
  logic [DEPTH_BITS-1:0]     da, db;
  logic [lca_pkg::STEP_W-1:0] steps;
  logic                      rd_oor;
  logic                      rd_side;

  logic [NW-1:0]         rd_node;
  logic                  rd_issue;
  logic [EW-1:0]         rd_data;
  logic [NW-1:0]         rd_par;
  logic [DEPTH_BITS-1:0] rd_dep;
  logic                  go_b;
  logic                  wr_en;

  // deeper side climbs; equal depth climbs a
  assign go_b = (da < db);

  always_comb begin
    rd_node = '0;
    if (cmd.load) begin
      rd_node = item.node_a;
    end else if (cmd.cap_a) begin
      rd_node = nb;
    end else if (cmd.step) begin
      rd_node = go_b ? pb : pa;
    end
  end

  assign rd_issue = cmd.load | cmd.cap_a | cmd.step;
  assign wr_en = cmd.write && (32'(item.node_a) < 32'(NODE_COUNT));

  lca_ram #(
    .WIDTH(EW),
    .DEPTH(NODE_COUNT)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(AW'(item.node_a)),
    .wr_data({item.parent_node, DEPTH_BITS'(item.node_depth)}),
    .rd_addr(AW'(rd_node)),
    .rd_data(rd_data)
  );

  // nodes past the table read as parent 0, depth 0
  assign rd_par = rd_oor ? '0 : rd_data[DEPTH_BITS +: NW];
  assign rd_dep = rd_oor ? '0 : rd_data[DEPTH_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rd_issue) begin
      rd_oor <= !(32'(rd_node) < 32'(NODE_COUNT));
    end
    if (cmd.load) begin
      na <= item.node_a;
      nb <= item.node_b;
    end
    if (cmd.cap_a) begin
      da <= rd_dep;
      pa <= rd_par;
    end
    if (cmd.cap_b) begin
      db <= rd_dep;
      pb <= rd_par;
    end
    if (cmd.step) begin
      rd_side <= go_b;
      if (go_b) begin
        nb <= pb;
      end else begin
        na <= pa;
      end
    end
    if (cmd.cap_step) begin
      if (rd_side) begin
        db <= rd_dep;
        pb <= rd_par;
      end else begin
        da <= rd_dep;
        pa <= rd_par;
      end
    end
    case (cmd.emit)
      lca_pkg::EMIT_PASS: begin
        result.ancestor <= (na != '0) ? na : nb;
        result.gave_up <= 1'b0;
      end
      lca_pkg::EMIT_MATCH: begin
        result.ancestor <= na;
        result.gave_up <= 1'b0;
      end
      lca_pkg::EMIT_GIVEUP: begin
        result.ancestor <= '0;
        result.gave_up <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done <= 1'b0;
    end else begin
      if (cmd.load) begin
        steps <= '0;
      end else if (cmd.step) begin
        steps <= steps + 1'b1;
      end
      done <= (cmd.emit != lca_pkg::EMIT_NONE);
    end
  end

  assign status.zero_case = (na == '0) || (nb == '0);
  assign status.nodes_equal = (na == nb);
  assign status.at_limit = (steps == lca_pkg::STEP_LIMIT);

endmodule
